// ----- hdl/clc_pkg.sv -----
// Shared types and constants for the centroid leader clusterer.
// No dependencies; used by every module in hdl/ except clc_ram.
`default_nettype none

package clc_pkg;

  // Point format and table size
  localparam int COORD_BITS  = 24;
  localparam int MAX_GROUPS  = 16;
  localparam int GRP_W       = $clog2(MAX_GROUPS);
  localparam int GCNT_W      = $clog2(MAX_GROUPS + 1);

  // Member counts and coordinate sums
  localparam int CNT_W       = 16;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam int SUM_W       = COORD_BITS + CNT_W;

  // Join radius register
  localparam int RAD_W       = 23;
  localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(512);

  // Distance datapath widths
  localparam int RCW         = RAD_W + CNT_W;            // radius * count
  localparam int PW          = COORD_BITS + CNT_W + 1;   // count * p, signed
  localparam int DW          = PW + 1;                   // count * p - sum, signed
  localparam int OPW         = (PW > RCW) ? PW : RCW;    // squaring operand
  localparam int LO          = (OPW + 1) / 2;            // low half of operand
  localparam int SQW         = 2 * OPW;                  // one square

  // Result reporting
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W       = 4;

  // Input queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Partial product steps of a square
  localparam logic [1:0] SQ_LO_LO = 2'd0;
  localparam logic [1:0] SQ_HI_LO = 2'd1;
  localparam logic [1:0] SQ_HI_HI = 2'd2;

  // One point as held in the queue
  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
    logic                         is_planar;
    logic                         first_of_batch;
  } point_t;

  // One group table entry
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic [CNT_W-1:0]        count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Back-end sequencer
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_DIFF = 7'b0000100,
    S_SQ   = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_CMP  = 7'b0100000,
    S_DONE = 7'b1000000
  } back_state_e;

endpackage

`default_nettype wire

// ----- hdl/centroid_leader_clusterer.sv -----
// Centroid leader clusterer, top level: radius register, front queue, back end.
// Depends on clc_pkg, clc_front, clc_back (and clc_ram through clc_back).
//
// Points are queued two deep by the front end, so the input keeps taking words
// while the back end works. The back end walks the open groups one at a time;
// each group passes through table read and count scaling, offset, three
// partial-product steps of the squares, sum, compare and update, and output
// stalls can hold the walk. Each join is held back until the next join or
// the end of the walk so that the last one carries last_result; a point that
// joins nothing gives one result (opened or full).
`default_nettype none

module centroid_leader_clusterer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [clc_pkg::RAD_W-1:0]         cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic signed [clc_pkg::COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [clc_pkg::COORD_BITS-1:0] pos_y_i,
  input  wire logic signed [clc_pkg::COORD_BITS-1:0] pos_z_i,
  input  wire logic                              is_planar_i,
  input  wire logic                              first_of_batch_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [clc_pkg::IDX_W-1:0]         group_index_o,
  output      logic                              opened_group_o,
  output      logic                              table_full_o,
  output      logic                              last_result_o
);

  logic [clc_pkg::RAD_W-1:0] radius_q;
  logic                      q_valid, q_pop;
  clc_pkg::point_t           q_item;

  // join radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= clc_pkg::RAD_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  clc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .is_planar_i      (is_planar_i),
    .first_of_batch_i (first_of_batch_i),
    .q_valid_o        (q_valid),
    .q_item_o         (q_item),
    .q_pop_i          (q_pop)
  );

  clc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .radius_i       (radius_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .group_index_o  (group_index_o),
    .opened_group_o (opened_group_o),
    .table_full_o   (table_full_o),
    .last_result_o  (last_result_o)
  );

  // a dropped point reports nothing else
  a_full_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |->
      last_result_o && !opened_group_o && group_index_o == '0)
    else $error("table-full word carries other flags");

  // opening a group is always the only result of its point
  a_open_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && opened_group_o |-> last_result_o && !table_full_o)
    else $error("opened-group word not marked last");

  // the queue only fills through an accepted word
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input stall rose without an incoming word");

endmodule

`default_nettype wire

// ----- hdl/clc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module clc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/clc_front.sv -----
// Front end: accepts point words and holds them in a short queue for the back end.
// Depends on clc_pkg.
`default_nettype none

module clc_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic signed [clc_pkg::COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [clc_pkg::COORD_BITS-1:0] pos_y_i,
  input  wire logic signed [clc_pkg::COORD_BITS-1:0] pos_z_i,
  input  wire logic                              is_planar_i,
  input  wire logic                              first_of_batch_i,
  output      logic                              q_valid_o,
  output      clc_pkg::point_t                   q_item_o,
  input  wire logic                              q_pop_i
);

  clc_pkg::point_t                 slot_q [clc_pkg::QUEUE_DEPTH];
  logic [clc_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [clc_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [clc_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                            full, push, pop;

  assign full       = (cnt_q == clc_pkg::QCNT_W'(clc_pkg::QUEUE_DEPTH));
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = slot_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == clc_pkg::QPTR_W'(clc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == clc_pkg::QPTR_W'(clc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{pos_x: pos_x_i, pos_y: pos_y_i, pos_z: pos_z_i,
                            is_planar: is_planar_i, first_of_batch: first_of_batch_i};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/clc_back.sv -----
// Back end: walks the group table for one point, tests distance, updates and reports.
// Depends on clc_pkg and clc_ram.
`default_nettype none

module clc_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [clc_pkg::RAD_W-1:0]      radius_i,
  input  wire logic                           q_valid_i,
  input  wire clc_pkg::point_t                q_item_i,
  output      logic                           q_pop_o,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [clc_pkg::IDX_W-1:0]      group_index_o,
  output      logic                           opened_group_o,
  output      logic                           table_full_o,
  output      logic                           last_result_o
);

  localparam int OPW = clc_pkg::OPW;
  localparam int LO  = clc_pkg::LO;
  localparam int SQW = clc_pkg::SQW;

  // magnitude of a signed difference
  function automatic logic [OPW-1:0] mag(input logic signed [clc_pkg::DW-1:0] d);
    logic signed [clc_pkg::DW-1:0] m;
    m = d[clc_pkg::DW-1] ? -d : d;
    return OPW'(m);
  endfunction

  clc_pkg::back_state_e state_q, state_d;

  // point under work
  logic signed [clc_pkg::COORD_BITS-1:0] px_q, py_q, pz_q;
  logic signed [clc_pkg::COORD_BITS-1:0] px_d, py_d, pz_d;
  logic                                  planar_q, planar_d;

  // walk control
  logic [clc_pkg::GRP_W-1:0]   g_q, g_d;
  logic [clc_pkg::GCNT_W-1:0]  ngrp_q, ngrp_d;
  logic [clc_pkg::NRES_W-1:0]  nres_q, nres_d;
  logic                        pend_q, pend_d;
  logic [clc_pkg::GRP_W-1:0]   pend_g_q, pend_g_d;
  logic [1:0]                  k_q, k_d;

  // datapath
  logic signed [clc_pkg::PW-1:0] prx_q, pry_q, prz_q, prx_d, pry_d, prz_d;
  logic [clc_pkg::RCW-1:0]       rc_q, rc_d;
  logic [OPW-1:0]                ax_q, ay_q, az_q, ar_q, ax_d, ay_d, az_d, ar_d;
  logic [SQW-1:0]                sx_q, sy_q, sz_q, sr_q, sx_d, sy_d, sz_d, sr_d;
  logic [SQW:0]                  dxy_q, dxy_d;

  // result register
  logic                        ov_q, ov_d;
  logic [clc_pkg::IDX_W-1:0]   oidx_q, oidx_d;
  logic                        oopen_q, oopen_d, ofull_q, ofull_d, olast_q, olast_d;

  // RAM port
  logic                        ram_we;
  logic [clc_pkg::GRP_W-1:0]   ram_waddr, ram_raddr;
  clc_pkg::entry_t             ram_wdata, ent;
  logic [clc_pkg::ENTRY_W-1:0] ram_rdata;

  assign ent = clc_pkg::entry_t'(ram_rdata);

  clc_ram #(
    .WIDTH (clc_pkg::ENTRY_W),
    .DEPTH (clc_pkg::MAX_GROUPS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // square partial products, one multiplier per operand, reused across the three steps
  logic [LO-1:0]    ma_x, mb_x, ma_y, mb_y, ma_z, mb_z, ma_r, mb_r;
  logic [2*LO-1:0]  pp_x, pp_y, pp_z, pp_r;
  logic [SQW-1:0]   sh_x, sh_y, sh_z, sh_r;

  always_comb begin
    ma_x = (k_q == clc_pkg::SQ_LO_LO) ? ax_q[LO-1:0] : LO'(ax_q >> LO);
    mb_x = (k_q == clc_pkg::SQ_HI_HI) ? LO'(ax_q >> LO) : ax_q[LO-1:0];
    ma_y = (k_q == clc_pkg::SQ_LO_LO) ? ay_q[LO-1:0] : LO'(ay_q >> LO);
    mb_y = (k_q == clc_pkg::SQ_HI_HI) ? LO'(ay_q >> LO) : ay_q[LO-1:0];
    ma_z = (k_q == clc_pkg::SQ_LO_LO) ? az_q[LO-1:0] : LO'(az_q >> LO);
    mb_z = (k_q == clc_pkg::SQ_HI_HI) ? LO'(az_q >> LO) : az_q[LO-1:0];
    ma_r = (k_q == clc_pkg::SQ_LO_LO) ? ar_q[LO-1:0] : LO'(ar_q >> LO);
    mb_r = (k_q == clc_pkg::SQ_HI_HI) ? LO'(ar_q >> LO) : ar_q[LO-1:0];
  end

  assign pp_x = ma_x * mb_x;
  assign pp_y = ma_y * mb_y;
  assign pp_z = ma_z * mb_z;
  assign pp_r = ma_r * mb_r;

  // place the partial product: cross term counts twice
  always_comb begin
    case (k_q)
      clc_pkg::SQ_LO_LO: begin
        sh_x = SQW'(pp_x);
        sh_y = SQW'(pp_y);
        sh_z = SQW'(pp_z);
        sh_r = SQW'(pp_r);
      end
      clc_pkg::SQ_HI_LO: begin
        sh_x = SQW'(pp_x) << (LO + 1);
        sh_y = SQW'(pp_y) << (LO + 1);
        sh_z = SQW'(pp_z) << (LO + 1);
        sh_r = SQW'(pp_r) << (LO + 1);
      end
      default: begin
        sh_x = SQW'(pp_x) << (2 * LO);
        sh_y = SQW'(pp_y) << (2 * LO);
        sh_z = SQW'(pp_z) << (2 * LO);
        sh_r = SQW'(pp_r) << (2 * LO);
      end
    endcase
  end

  // distance compare
  logic [SQW+1:0]              dsq;
  logic                        hit, emit_prev, out_free, can_go, more;
  logic [clc_pkg::GCNT_W-1:0]  g_next;

  assign dsq      = (SQW+2)'(dxy_q) + (planar_q ? '0 : (SQW+2)'(sz_q));
  assign hit      = dsq < (SQW+2)'(sr_q);
  assign out_free = !ov_q || !out_stall_i;
  assign emit_prev = hit && (nres_q < clc_pkg::NRES_W'(clc_pkg::MAX_RESULTS)) && pend_q;
  assign can_go   = !emit_prev || out_free;
  assign g_next   = clc_pkg::GCNT_W'(g_q) + 1'b1;
  assign more     = (g_next < ngrp_q) && (planar_q || !hit);

  // sequencer
  always_comb begin
    state_d  = state_q;
    px_d = px_q;  py_d = py_q;  pz_d = pz_q;  planar_d = planar_q;
    g_d      = g_q;
    ngrp_d   = ngrp_q;
    nres_d   = nres_q;
    pend_d   = pend_q;
    pend_g_d = pend_g_q;
    k_d      = k_q;
    prx_d = prx_q;  pry_d = pry_q;  prz_d = prz_q;  rc_d = rc_q;
    ax_d = ax_q;  ay_d = ay_q;  az_d = az_q;  ar_d = ar_q;
    sx_d = sx_q;  sy_d = sy_q;  sz_d = sz_q;  sr_d = sr_q;
    dxy_d    = dxy_q;
    q_pop_o  = 1'b0;
    ram_we   = 1'b0;
    ram_waddr = g_q;
    ram_wdata = ent;
    ram_raddr = g_q;
    // result register drains when taken
    ov_d    = ov_q && out_stall_i;
    oidx_d  = oidx_q;
    oopen_d = oopen_q;
    ofull_d = ofull_q;
    olast_d = olast_q;

    case (state_q)
      clc_pkg::S_IDLE: begin
        ram_raddr = '0;
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          px_d     = q_item_i.pos_x;
          py_d     = q_item_i.pos_y;
          pz_d     = q_item_i.pos_z;
          planar_d = q_item_i.is_planar;
          g_d      = '0;
          nres_d   = '0;
          pend_d   = 1'b0;
          if (q_item_i.first_of_batch) begin
            ngrp_d = '0;
          end
          if (q_item_i.first_of_batch || ngrp_q == '0) begin
            state_d = clc_pkg::S_DONE;
          end else begin
            state_d = clc_pkg::S_MUL;
          end
        end
      end

      // scale the point by the group count
      clc_pkg::S_MUL: begin
        prx_d   = $signed({1'b0, ent.count}) * px_q;
        pry_d   = $signed({1'b0, ent.count}) * py_q;
        prz_d   = $signed({1'b0, ent.count}) * pz_q;
        rc_d    = radius_i * ent.count;
        state_d = clc_pkg::S_DIFF;
      end

      // per-axis offset from the sum
      clc_pkg::S_DIFF: begin
        ax_d    = mag(clc_pkg::DW'(prx_q) - clc_pkg::DW'(ent.sum_x));
        ay_d    = mag(clc_pkg::DW'(pry_q) - clc_pkg::DW'(ent.sum_y));
        az_d    = mag(clc_pkg::DW'(prz_q) - clc_pkg::DW'(ent.sum_z));
        ar_d    = OPW'(rc_q);
        k_d     = clc_pkg::SQ_LO_LO;
        state_d = clc_pkg::S_SQ;
      end

      // squares in three partial-product steps
      clc_pkg::S_SQ: begin
        if (k_q == clc_pkg::SQ_LO_LO) begin
          sx_d = sh_x;  sy_d = sh_y;  sz_d = sh_z;  sr_d = sh_r;
        end else begin
          sx_d = sx_q + sh_x;  sy_d = sy_q + sh_y;
          sz_d = sz_q + sh_z;  sr_d = sr_q + sh_r;
        end
        if (k_q == clc_pkg::SQ_HI_HI) begin
          state_d = clc_pkg::S_SUM;
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      clc_pkg::S_SUM: begin
        dxy_d   = (SQW+1)'(sx_q) + (SQW+1)'(sy_q);
        state_d = clc_pkg::S_CMP;
      end

      // join decision, table update, walk on
      clc_pkg::S_CMP: begin
        if (can_go) begin
          if (hit && ent.count != clc_pkg::COUNT_MAX) begin
            ram_we    = 1'b1;
            ram_wdata.count = ent.count + 1'b1;
            ram_wdata.sum_x = ent.sum_x + clc_pkg::SUM_W'(px_q);
            ram_wdata.sum_y = ent.sum_y + clc_pkg::SUM_W'(py_q);
            ram_wdata.sum_z = ent.sum_z + clc_pkg::SUM_W'(pz_q);
          end
          if (hit && nres_q < clc_pkg::NRES_W'(clc_pkg::MAX_RESULTS)) begin
            if (pend_q) begin
              ov_d    = 1'b1;
              oidx_d  = clc_pkg::IDX_W'(pend_g_q);
              oopen_d = 1'b0;
              ofull_d = 1'b0;
              olast_d = 1'b0;
            end
            pend_d   = 1'b1;
            pend_g_d = g_q;
            nres_d   = nres_q + 1'b1;
          end
          if (more) begin
            g_d       = clc_pkg::GRP_W'(g_next);
            ram_raddr = clc_pkg::GRP_W'(g_next);
            state_d   = clc_pkg::S_MUL;
          end else begin
            state_d = clc_pkg::S_DONE;
          end
        end
      end

      // final result: last join, new group or table full
      clc_pkg::S_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          olast_d = 1'b1;
          oopen_d = 1'b0;
          ofull_d = 1'b0;
          oidx_d  = '0;
          if (pend_q) begin
            oidx_d = clc_pkg::IDX_W'(pend_g_q);
          end else if (ngrp_q < clc_pkg::GCNT_W'(clc_pkg::MAX_GROUPS)) begin
            ram_we          = 1'b1;
            ram_waddr       = clc_pkg::GRP_W'(ngrp_q);
            ram_wdata.count = clc_pkg::CNT_W'(1);
            ram_wdata.sum_x = clc_pkg::SUM_W'(px_q);
            ram_wdata.sum_y = clc_pkg::SUM_W'(py_q);
            ram_wdata.sum_z = clc_pkg::SUM_W'(pz_q);
            ngrp_d          = ngrp_q + 1'b1;
            oidx_d          = clc_pkg::IDX_W'(ngrp_q);
            oopen_d         = 1'b1;
          end else begin
            ofull_d = 1'b1;
          end
          state_d = clc_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = clc_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clc_pkg::S_IDLE;
      ngrp_q  <= '0;
      ov_q    <= 1'b0;
      g_q     <= '0;
      nres_q  <= '0;
      pend_q  <= 1'b0;
      k_q     <= clc_pkg::SQ_LO_LO;
    end else begin
      state_q <= state_d;
      ngrp_q  <= ngrp_d;
      ov_q    <= ov_d;
      g_q     <= g_d;
      nres_q  <= nres_d;
      pend_q  <= pend_d;
      k_q     <= k_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    px_q <= px_d;  py_q <= py_d;  pz_q <= pz_d;  planar_q <= planar_d;
    pend_g_q <= pend_g_d;
    prx_q <= prx_d;  pry_q <= pry_d;  prz_q <= prz_d;  rc_q <= rc_d;
    ax_q <= ax_d;  ay_q <= ay_d;  az_q <= az_d;  ar_q <= ar_d;
    sx_q <= sx_d;  sy_q <= sy_d;  sz_q <= sz_d;  sr_q <= sr_d;
    dxy_q <= dxy_d;
    oidx_q <= oidx_d;  oopen_q <= oopen_d;  ofull_q <= ofull_d;  olast_q <= olast_d;
  end

  assign out_valid_o    = ov_q;
  assign group_index_o  = oidx_q;
  assign opened_group_o = oopen_q;
  assign table_full_o   = ofull_q;
  assign last_result_o  = olast_q;

endmodule

`default_nettype wire
